@@ rtl/double_ended_queue_macros.svh @@
// assertion macros used by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define DEQ_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/deq_pkg.sv @@
// shared types, codes and defaults of the double-ended queue
package deq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_W          = 3;
  localparam int FIELD_W        = 32;
  localparam int STATUS_W       = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // cell operations
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_SHR  = 2'd1;  // take value of lower neighbor
  localparam logic [1:0] CELL_SHL  = 2'd2;  // take value of upper neighbor
  localparam logic [1:0] CELL_LOAD = 2'd3;  // load write data at back slot

  typedef struct packed {
    logic [1:0] op;
    logic       load_en;
  } deq_cell_ctrl_t;

endpackage

@@ rtl/deq_cell.sv @@
// one storage cell of the queue chain
module deq_cell
  import deq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  deq_cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] cell_data
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_SHR: data_nxt = left_data;
      CELL_SHL: data_nxt = right_data;
      CELL_LOAD: begin
        if (ctrl.load_en && (count == CNT_W'(IDX))) data_nxt = wr_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_data = data_r;

endmodule

@@ rtl/double_ended_queue.sv @@
// top level of the double-ended queue built as a chain of cells
// Bounded double-ended queue of DEPTH signed entries held in a row of cells,
// cell 0 always the front. Commands arrive on the in_ channel (cmd in tuser,
// value in tdata); every command gives one or more result transfers on the
// out_ channel. Push front shifts the whole row up one cell, push back loads
// the cell at the current count, pop front shifts the row down, pop back only
// drops the count. The next command can be accepted as soon as the result of
// a push or pop is taken, so one transfer per cycle is sustained while the
// receiver stays ready. A dump of n entries gives no result on its start and
// then 2*n results: the row rotates one cell per result taken, first downward
// while cell 0 is emitted front to back, then upward while the top cell is
// emitted back to front, which returns the row to its original order; tlast
// marks the final result. A dump of an empty queue gives one result with
// status empty. The cells have no reset and need no clearing pass: only cells
// below the count are ever emitted, and those were written.
`include "double_ended_queue_macros.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [2:0]  out_tuser,  // [0] backward_pass, [2:1] status
  output logic        out_tlast   // last
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FWD  = 2'd1;
  localparam logic [1:0] S_BWD  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]  out_data_r, out_data_nxt;
  logic                out_back_r, out_back_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_xfer;
  logic                  is_full;
  logic                  is_empty;
  logic                  step_end;
  logic [CMD_W-1:0]      cmd;
  logic [DATA_WIDTH-1:0] store_val;
  logic [DATA_WIDTH-1:0] front_val;
  logic [DATA_WIDTH-1:0] top_val;
  logic [FIELD_W-1:0]    front_ext;
  logic [FIELD_W-1:0]    top_ext;
  logic [DATA_WIDTH-1:0] left0;
  deq_cell_ctrl_t        cell_ctrl;

  logic [DATA_WIDTH-1:0] cells [DEPTH];

  assign cmd       = in_tuser;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign step_end  = (step_r == (count_r - CNT_W'(1)));
  assign front_val = cells[0];
  assign top_val   = cells[DEPTH-1];

  // width conversion between the 32-bit fields and the stored width
  generate
    if (DATA_WIDTH <= FIELD_W) begin : g_narrow
      assign store_val = in_tdata[DATA_WIDTH-1:0];
      if (DATA_WIDTH < FIELD_W) begin : g_ext
        assign front_ext = {{(FIELD_W-DATA_WIDTH){front_val[DATA_WIDTH-1]}}, front_val};
        assign top_ext   = {{(FIELD_W-DATA_WIDTH){top_val[DATA_WIDTH-1]}}, top_val};
      end else begin : g_same
        assign front_ext = front_val;
        assign top_ext   = top_val;
      end
    end else begin : g_wide
      assign store_val = {{(DATA_WIDTH-FIELD_W){in_tdata[FIELD_W-1]}}, in_tdata};
      assign front_ext = front_val[FIELD_W-1:0];
      assign top_ext   = top_val[FIELD_W-1:0];
    end
  endgenerate

  // cell 0 takes the pushed value, or the top cell while rotating upward
  assign left0 = (state_r == S_BWD) ? top_val : store_val;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_back_nxt   = out_back_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    cell_ctrl      = '{op: CELL_HOLD, load_en: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          // default single result: ok, last
          out_valid_nxt  = 1'b1;
          out_data_nxt   = '0;
          out_back_nxt   = 1'b0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          case (cmd)
            CMD_DUMP: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // no result on the start cycle, the stream begins in the forward pass
                out_valid_nxt = out_valid_r && !out_tready;
                step_nxt      = '0;
                state_nxt     = S_FWD;
              end
            end
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_ctrl.op = CELL_SHR;
                count_nxt    = count_r + CNT_W'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (is_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                cell_ctrl = '{op: CELL_LOAD, load_en: 1'b1};
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                cell_ctrl.op = CELL_SHL;
                count_nxt    = count_r - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_FWD: begin
        if (out_free) begin
          // emit the front cell, rotate the row downward
          out_valid_nxt  = 1'b1;
          out_data_nxt   = front_ext;
          out_back_nxt   = 1'b0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b0;
          cell_ctrl.op   = CELL_SHL;
          if (step_end) begin
            step_nxt  = '0;
            state_nxt = S_BWD;
          end else begin
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      S_BWD: begin
        if (out_free) begin
          // emit the top cell, rotate the row upward
          out_valid_nxt  = 1'b1;
          out_data_nxt   = top_ext;
          out_back_nxt   = 1'b1;
          out_status_nxt = ST_OK;
          out_last_nxt   = step_end;
          cell_ctrl.op   = CELL_SHR;
          if (step_end) begin
            step_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_back_r   <= out_back_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // the cell chain, cell 0 wraps to the top cell on downward rotation
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_in;
      if (gi == 0) begin : g_first
        assign left_in = left0;
      end else begin : g_rest
        assign left_in = cells[gi-1];
      end
      deq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX        (gi)
      ) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .count      (count_r),
        .wr_data    (store_val),
        .left_data  (left_in),
        .right_data (cells[(gi + 1) % DEPTH]),
        .cell_data  (cells[gi])
      );
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_status_r, out_back_r};
  assign out_tlast  = out_last_r;

  // count never passes the capacity
  `DEQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above depth")
  // a dump only runs over a non-empty queue and the step stays inside it
  `DEQ_ASSERT_ALWAYS(a_dump_range, (state_r == S_IDLE) || (step_r < count_r),
                     "dump step outside live entries")
  // the count holds while a dump streams
  `DEQ_ASSERT_NEXT(a_dump_count, state_r != S_IDLE, $stable(count_r),
                   "entry count changed during dump")
  // a backward pass never starts without a forward pass before it
  `DEQ_ASSERT_NEXT(a_bwd_entry, (state_r == S_IDLE), (state_r != S_BWD),
                   "backward pass entered from idle")

endmodule

@@ verif/double_ended_queue_tb.sv @@
// self-checking testbench for the double-ended queue with a scoreboard class and stream drivers
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int DW          = DATA_WIDTH_DEF;
  localparam int N_RANDOM    = 180;
  localparam int MAX_GAP     = 8;
  localparam int LONG_HOLD   = 300;
  localparam int SHOW_LIMIT  = 10;
  // a full dump is 2*DEPTH transfers after its start
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  // worst item: 32 results each behind a full stall, plus sender gap, times several
  localparam int CYCLE_LIMIT = 400000;

  // codes outside the defined command set, answered with a plain ok
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  // random command mix, one per run of items
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} cmd_mix_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  data_out;
    logic                backward_pass;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deq_result_t;

  // ring-buffer copy of the queue plus the results still owed by the block
  class deque_tracker;
    logic [DW-1:0] ring [DEPTH];
    int unsigned   head;
    int unsigned   count;
    deq_result_t   pending_results [$];
    int unsigned   fails;
    int unsigned   shown;

    function new();
      head  = 0;
      count = 0;
      fails = 0;
      shown = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void owe(logic [FIELD_W-1:0] d, logic back, logic [STATUS_W-1:0] st,
                      logic lst);
      deq_result_t r;
      r.data_out      = d;
      r.backward_pass = back;
      r.status        = st;
      r.last          = lst;
      pending_results.push_back(r);
    endfunction

    // apply one accepted command and queue up the transfers it causes
    function void note_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] value);
      logic [DW-1:0]        entry;
      logic signed [DW-1:0] stored;
      entry = DW'($signed(value));
      case (cmd)
        CMD_DUMP: begin
          if (count == 0) begin
            owe('0, 1'b0, ST_EMPTY, 1'b1);
          end else begin
            for (int i = 0; i < int'(count); i++) begin
              stored = ring[(head + i) % DEPTH];
              owe(FIELD_W'(stored), 1'b0, ST_OK, 1'b0);
            end
            for (int i = int'(count); i > 0; i--) begin
              stored = ring[(head + i - 1) % DEPTH];
              owe(FIELD_W'(stored), 1'b1, ST_OK, i == 1);
            end
          end
        end
        CMD_PUSH_FRONT: begin
          if (count >= DEPTH) begin
            owe('0, 1'b0, ST_FULL, 1'b1);
          end else begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = entry;
            count++;
            owe('0, 1'b0, ST_OK, 1'b1);
          end
        end
        CMD_PUSH_BACK: begin
          if (count >= DEPTH) begin
            owe('0, 1'b0, ST_FULL, 1'b1);
          end else begin
            ring[(head + count) % DEPTH] = entry;
            count++;
            owe('0, 1'b0, ST_OK, 1'b1);
          end
        end
        CMD_POP_FRONT: begin
          if (count == 0) begin
            owe('0, 1'b0, ST_EMPTY, 1'b1);
          end else begin
            head = (head + 1) % DEPTH;
            count--;
            owe('0, 1'b0, ST_OK, 1'b1);
          end
        end
        CMD_POP_BACK: begin
          if (count == 0) begin
            owe('0, 1'b0, ST_EMPTY, 1'b1);
          end else begin
            count--;
            owe('0, 1'b0, ST_OK, 1'b1);
          end
        end
        default: begin
          owe('0, 1'b0, ST_OK, 1'b1);
        end
      endcase
    endfunction

    // compare one result transfer against the oldest owed result
    function void check_result(deq_result_t got);
      deq_result_t want;
      if (pending_results.size() == 0) begin
        fails++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("unexpected result: data_out %h backward %b status %0d last %b",
                   got.data_out, got.backward_pass, got.status, got.last);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.data_out !== want.data_out || got.backward_pass !== want.backward_pass ||
          got.status !== want.status || got.last !== want.last) begin
        fails++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("mismatch: data_out exp %h got %h, backward exp %b got %b",
                   want.data_out, got.data_out, want.backward_pass, got.backward_pass);
          $display("          status exp %0d got %0d, last exp %b got %b",
                   want.status, got.status, want.last, got.last);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [FIELD_W-1:0] in_tdata;   // [31:0] data_in
  logic [CMD_W-1:0]   in_tuser;   // [2:0] cmd
  logic               out_tvalid;
  logic               out_tready;
  logic [FIELD_W-1:0] out_tdata;  // [31:0] data_out
  logic [2:0]         out_tuser;  // [0] backward_pass, [2:1] status
  logic               out_tlast;  // last

  deque_tracker sb;
  int unsigned  cycle_count;
  // long receiver hold-off requested by the stimulus, taken by the receiver
  int unsigned  hold_req;
  // both sides run without gaps while this is set
  bit           quiet;

  double_ended_queue #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // offer one command on the input channel and wait for its transfer;
  // entered and left at a falling edge
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_command(cmd, value);
    @(negedge clk);
  endtask

  // result side: random stalls, plus the long hold-off when one is requested
  task automatic take_results();
    int unsigned gap;
    deq_result_t got;
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_req != 0) begin
        gap      = hold_req;
        hold_req = 0;
      end
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got.data_out      = out_tdata;
      got.backward_pass = out_tuser[0];
      got.status        = out_tuser[2:1];
      got.last          = out_tlast;
      sb.check_result(got);
      @(negedge clk);
    end
  endtask

  // pause the sender until every owed result has been taken
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_results.size() != 0);
  endtask

  function automatic logic [CMD_W-1:0] push_either_end();
    return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
  endfunction

  function automatic logic [CMD_W-1:0] pop_either_end();
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  function automatic logic [CMD_W-1:0] CMD_CODE_SPARE();
    return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
  endfunction

  // pick a command for the current mix; fill and drain runs walk the queue
  // between its empty and full boundaries
  function automatic logic [CMD_W-1:0] pick_cmd(cmd_mix_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 85) return push_either_end();
        if (r < 95) return CMD_DUMP;
        return pop_either_end();
      end
      MIX_DRAIN: begin
        if (r < 85) return pop_either_end();
        if (r < 95) return CMD_DUMP;
        return push_either_end();
      end
      MIX_BALANCED: begin
        if (r < 40) return push_either_end();
        if (r < 80) return pop_either_end();
        if (r < 92) return CMD_DUMP;
        return CMD_CODE_SPARE();
      end
      default: begin
        return CMD_W'($urandom_range(int'(CMD_DUMP), int'(CMD_SPARE_LAST)));
      end
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run_len;
    cmd_mix_t    mix;
    logic [FIELD_W-1:0] fill_value;

    sb         = new();
    hold_req   = 0;
    quiet      = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_DUMP;
    out_tready = 1'b0;

    // synchronous reset held low, then released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    fork
      take_results();
    join_none

    // empty queue: both pops report empty, dump gives the lone empty status
    send_cmd(CMD_POP_FRONT, $urandom());
    send_cmd(CMD_POP_BACK, $urandom());
    send_cmd(CMD_DUMP, $urandom());
    // codes beyond the command set
    for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++) begin
      send_cmd(CMD_W'(c), $urandom());
    end

    // fill to the top from both ends, value extremes first
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       fill_value = 32'h8000_0000;
        1:       fill_value = 32'h7fff_ffff;
        2:       fill_value = 32'h0000_0000;
        3:       fill_value = 32'hffff_ffff;
        default: fill_value = $urandom();
      endcase
      send_cmd((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, fill_value);
    end
    // pushes on a full queue are refused at either end
    send_cmd(CMD_PUSH_FRONT, $urandom());
    send_cmd(CMD_PUSH_BACK, $urandom());
    // dump of a full queue, then one pop from each end
    send_cmd(CMD_DUMP, $urandom());
    send_cmd(CMD_POP_FRONT, $urandom());
    send_cmd(CMD_POP_BACK, $urandom());

    // random runs of one command mix each
    sent = 0;
    while (sent < N_RANDOM) begin
      mix     = cmd_mix_t'($urandom_range(0, 3));
      run_len = $urandom_range(4, 16);
      repeat (run_len) begin
        // receiver stalls for a long stretch, sender keeps offering
        if (sent == 60) hold_req = LONG_HOLD;
        // sender idles until every owed result has arrived
        if (sent == 120) wait_for_drain();
        quiet = (sent >= 90 && sent < 110);
        send_cmd(pick_cmd(mix), $urandom());
        sent++;
      end
    end
    quiet     = 1'b0;
    in_tvalid <= 1'b0;

    // let every owed result arrive, then watch for stray transfers
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (sb.fails == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
verif/double_ended_queue_tb.sv
